@@ design/olmr_pkg.sv @@
// Shared constants, types and codes for the ordered list block.
`timescale 1ns / 1ps

package olmr_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ID_W      = 11;
    localparam int ACT_W     = 3;
    localparam int OFF_W     = 2;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W     = (ID_W > CNT_W) ? ID_W : CNT_W;
    localparam int TGT_W     = CNT_W + 1;
    localparam int GRP_SIZE  = 32;
    localparam int NUM_GRP   = (MAX_ITEMS + GRP_SIZE - 1) / GRP_SIZE;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 3'd0,
        ACT_TOP    = 3'd1,
        ACT_BOTTOM = 3'd2,
        ACT_SHIFT  = 3'd3,
        ACT_ASK    = 3'd4,
        ACT_QUERY  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RESOLVE,
        ST_APPLY
    } state_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic [ID_W-1:0]  key_id;
        logic             pos_ok;
        logic [IDX_W-1:0] pos_idx;
        logic [CNT_W-1:0] count;
        logic             apply;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
        logic [ID_W-1:0]  new_id;
    } cell_ctl_t;

endpackage

@@ design/ordered_list_move_and_rank.sv @@
// Top level: ordered id list built from a row of shifting cells.
// Timing: after acceptance the match is registered in the first OR-tree level (look),
//   then resolved and registered to the output (resolve), stalling there while the
//   output is full; a load or move then adds an apply state for the broadcast shift
//   across the cell row. A new transaction is taken only in idle, one at a time.
// Reset (async, active low) empties the list; cell contents are not cleared.
`timescale 1ns / 1ps

module ordered_list_move_and_rank (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [olmr_pkg::ACT_W-1:0]    action,
    input  logic [olmr_pkg::ID_W-1:0]     item_id,
    input  logic signed [olmr_pkg::OFF_W-1:0] offset,
    input  logic [olmr_pkg::ID_W-1:0]     position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [olmr_pkg::ID_W-1:0]     answer,
    output logic                          error_flag
);
    import olmr_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ID_W-1:0]          answer_reg, answer_next;
    logic                     error_reg, error_next;
    logic [ACT_W-1:0]         act_reg, act_next;
    logic [ID_W-1:0]          key_reg, key_next;
    logic signed [OFF_W-1:0]  off_reg, off_next;
    logic [ID_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]         src_reg, src_next;
    logic [IDX_W-1:0]         dst_reg, dst_next;
    logic [ID_W-1:0]          newid_reg, newid_next;

    cell_ctl_t                ctl;
    logic [ID_W-1:0]          cell_id [MAX_ITEMS];
    logic [ID_W-1:0]          cell_sel [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     cell_hit;
    logic [NUM_GRP-1:0]       grp_found;
    logic [IDX_W-1:0]         grp_slot [NUM_GRP];
    logic [ID_W-1:0]          grp_qid [NUM_GRP];

    logic                     found;
    logic [IDX_W-1:0]         slot;
    logic [ID_W-1:0]          qid;
    logic                     pos_ok;
    logic signed [TGT_W-1:0]  tgt;
    logic                     res_err;
    logic                     res_emit;
    logic                     res_move;
    logic [IDX_W-1:0]         res_dst;
    logic                     stall;

    // ---------------- cell row ----------------
    assign pos_ok = (pos_reg != '0) && (CMP_W'(pos_reg) <= CMP_W'(count_reg));

    assign ctl.key_id  = key_reg;
    assign ctl.pos_ok  = pos_ok;
    assign ctl.pos_idx = IDX_W'(pos_reg - ID_W'(1));
    assign ctl.count   = count_reg;
    assign ctl.apply   = (state_reg == ST_APPLY);
    assign ctl.src     = src_reg;
    assign ctl.dst     = dst_reg;
    assign ctl.new_id  = newid_reg;

    genvar k;
    for (k = 0; k < MAX_ITEMS; k++)
    begin : g_cell
        logic [ID_W-1:0] left_w;
        logic [ID_W-1:0] right_w;

        if (k == 0)
        begin : g_head
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_id[k-1];
        end

        if (k == MAX_ITEMS - 1)
        begin : g_tail
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_id[k+1];
        end

        olmr_cell u_cell (
            .clk      (clk),
            .idx      (IDX_W'(k)),
            .ctl      (ctl),
            .left_id  (left_w),
            .right_id (right_w),
            .id       (cell_id[k]),
            .hit      (cell_hit[k]),
            .sel_id   (cell_sel[k])
        );
    end

    olmr_reduce u_reduce (
        .clk       (clk),
        .hit       (cell_hit),
        .sel_id    (cell_sel),
        .grp_found (grp_found),
        .grp_slot  (grp_slot),
        .grp_qid   (grp_qid)
    );

    // second level of the OR tree
    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        qid   = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            found = found | grp_found[g];
            slot  = slot | grp_slot[g];
            qid   = qid | grp_qid[g];
        end
    end

    // ---------------- decision ----------------
    always_comb
    begin
        tgt      = $signed(TGT_W'(slot)) + TGT_W'(off_reg);
        res_err  = 1'b0;
        res_emit = 1'b0;
        res_move = 1'b0;
        res_dst  = slot;
        answer_next = '0;
        case (act_reg)
            ACT_LOAD:
            begin
                res_err = (key_reg == '0) || (CMP_W'(key_reg) > CMP_W'(MAX_ITEMS))
                          || found || (count_reg == CNT_W'(MAX_ITEMS));
                res_move = !res_err;
                res_dst  = IDX_W'(count_reg);
            end
            ACT_TOP:
            begin
                res_err  = !found;
                res_move = found;
                res_dst  = '0;
            end
            ACT_BOTTOM:
            begin
                res_err  = !found;
                res_move = found;
                res_dst  = IDX_W'(count_reg - CNT_W'(1));
            end
            ACT_SHIFT:
            begin
                res_err  = !found || (tgt < 0) || (tgt >= $signed(TGT_W'(count_reg)));
                res_move = !res_err;
                res_dst  = tgt[IDX_W-1:0];
            end
            ACT_ASK:
            begin
                res_err     = !found;
                res_emit    = 1'b1;
                answer_next = found ? ID_W'(slot) : '0;
            end
            ACT_QUERY:
            begin
                res_err     = !pos_ok;
                res_emit    = 1'b1;
                answer_next = pos_ok ? qid : '0;
            end
            default:
            begin
                res_err = 1'b1;
            end
        endcase
        if (res_err)
        begin
            res_emit    = 1'b1;
            answer_next = '0;
        end
        error_next = res_err;
        stall      = res_emit && out_valid_reg && !out_ready;
    end

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (!stall)
                begin
                    state_next = res_move ? ST_APPLY : ST_IDLE;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        act_next       = act_reg;
        key_next       = key_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        newid_next     = newid_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_valid && in_ready)
        begin
            act_next = action;
            key_next = item_id;
            off_next = offset;
            pos_next = position;
        end
        if (state_reg == ST_RESOLVE && !stall)
        begin
            if (res_emit)
            begin
                out_valid_next = 1'b1;
            end
            if (res_move)
            begin
                // a load writes one new slot at the tail
                src_next   = (act_reg == ACT_LOAD) ? IDX_W'(count_reg) : slot;
                dst_next   = res_dst;
                newid_next = key_reg;
                if (act_reg == ACT_LOAD)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        off_reg   <= off_next;
        pos_reg   <= pos_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        newid_reg <= newid_next;
        if (state_reg == ST_RESOLVE && !stall && res_emit)
        begin
            answer_reg <= answer_next;
            error_reg  <= error_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign answer     = answer_reg;
    assign error_flag = error_reg;

    // ---------------- assertions ----------------
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) && (state_reg == ST_APPLY))
        else $error("list count changed other than by one load");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_ITEMS))
        else $error("list count above capacity");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESOLVE) |-> $onehot0(grp_found))
        else $error("id found in more than one slot group");

    a_apply_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |=> (state_reg == ST_IDLE) && $stable(answer_reg))
        else $error("shift cycle did not return to idle");

endmodule

@@ design/olmr_cell.sv @@
// One slot of the list: holds an id, matches it and shifts with its neighbors.
`timescale 1ns / 1ps

module olmr_cell (
    input  logic                        clk,
    input  logic [olmr_pkg::IDX_W-1:0]  idx,
    input  olmr_pkg::cell_ctl_t         ctl,
    input  logic [olmr_pkg::ID_W-1:0]   left_id,
    input  logic [olmr_pkg::ID_W-1:0]   right_id,
    output logic [olmr_pkg::ID_W-1:0]   id,
    output logic                        hit,
    output logic [olmr_pkg::ID_W-1:0]   sel_id
);
    import olmr_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            filled;

    always_comb
    begin
        filled  = CNT_W'(idx) < ctl.count;
        id_next = id_reg;
        if (ctl.apply)
        begin
            if (idx == ctl.dst)
            begin
                id_next = ctl.new_id;
            end
            else if (ctl.src < ctl.dst && idx >= ctl.src && idx < ctl.dst)
            begin
                id_next = right_id;
            end
            else if (ctl.src > ctl.dst && idx > ctl.dst && idx <= ctl.src)
            begin
                id_next = left_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id     = id_reg;
    assign hit    = filled && (id_reg == ctl.key_id);
    // pos_ok already implies the slot is filled
    assign sel_id = (ctl.pos_ok && idx == ctl.pos_idx) ? id_reg : '0;

endmodule

@@ design/olmr_reduce.sv @@
// Registered first level of the OR tree that collects match slot and selected id.
`timescale 1ns / 1ps

module olmr_reduce (
    input  logic                         clk,
    input  logic [olmr_pkg::MAX_ITEMS-1:0] hit,
    input  logic [olmr_pkg::ID_W-1:0]    sel_id [olmr_pkg::MAX_ITEMS],
    output logic [olmr_pkg::NUM_GRP-1:0] grp_found,
    output logic [olmr_pkg::IDX_W-1:0]   grp_slot [olmr_pkg::NUM_GRP],
    output logic [olmr_pkg::ID_W-1:0]    grp_qid [olmr_pkg::NUM_GRP]
);
    import olmr_pkg::*;

    logic [NUM_GRP-1:0] found_next;
    logic [IDX_W-1:0]   slot_next [NUM_GRP];
    logic [ID_W-1:0]    qid_next [NUM_GRP];
    logic [NUM_GRP-1:0] found_reg;
    logic [IDX_W-1:0]   slot_reg [NUM_GRP];
    logic [ID_W-1:0]    qid_reg [NUM_GRP];

    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            found_next[g] = 1'b0;
            slot_next[g]  = '0;
            qid_next[g]   = '0;
            for (int m = 0; m < GRP_SIZE; m++)
            begin
                if (g * GRP_SIZE + m < MAX_ITEMS)
                begin
                    // ids are distinct, so at most one hit across the row
                    if (hit[g * GRP_SIZE + m])
                    begin
                        slot_next[g] = slot_next[g] | IDX_W'(g * GRP_SIZE + m);
                    end
                    found_next[g] = found_next[g] | hit[g * GRP_SIZE + m];
                    qid_next[g]   = qid_next[g] | sel_id[g * GRP_SIZE + m];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        slot_reg  <= slot_next;
        qid_reg   <= qid_next;
    end

    assign grp_found = found_reg;
    assign grp_slot  = slot_reg;
    assign grp_qid   = qid_reg;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the ordered id list block (move, rank and select).
`timescale 1ns / 1ps

module testbench;
    import olmr_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

    localparam logic [OFF_W-1:0] OFF_UP   = 2'b11;
    localparam logic [OFF_W-1:0] OFF_STAY = 2'b00;
    localparam logic [OFF_W-1:0] OFF_DOWN = 2'b01;
    localparam logic [OFF_W-1:0] OFF_WRAP = 2'b10;

    localparam int ID_SPAN        = 1 << ID_W;
    localparam int TAIL_ITEMS     = 60;
    localparam int PAUSE_MID      = 800;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int PAUSE_OFF   = 0;
    localparam int PAUSE_ENTER = 1;
    localparam int PAUSE_WAIT  = 2;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [ID_W-1:0]  id;
        logic [OFF_W-1:0] off;
        logic [ID_W-1:0]  pos;
    } shelf_op_t;

    typedef struct packed {
        logic [ID_W-1:0] answer;
        logic            err;
    } verdict_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [ACT_W-1:0]        action     = '0;
    logic [ID_W-1:0]         item_id    = '0;
    logic signed [OFF_W-1:0] offset     = '0;
    logic [ID_W-1:0]         position   = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic [ID_W-1:0]         answer;
    logic                    error_flag;

    // stimulus side
    shelf_op_t   pending[$];
    int unsigned id_pool[$];
    int unsigned gen_members[$];
    bit          gen_member[0:ID_SPAN-1];
    int unsigned front_guess = 0;
    int unsigned back_guess  = 0;
    int          pause_first = 0;
    int          n_total     = 0;

    // prediction side
    int unsigned shelf[$];
    verdict_t    verdicts[$];
    logic        drained = 1'b1;

    int n_sent      = 0;
    int n_fail      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int drv_calm    = 0;
    int mon_calm    = 0;
    int pause_state = PAUSE_OFF;
    int quiet       = 0;
    shelf_op_t cur;

    ordered_list_move_and_rank u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .item_id    (item_id),
        .offset     (offset),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .answer     (answer),
        .error_flag (error_flag)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned pick_unknown();
        if (id_pool.size() > 0 && $urandom_range(0, 1) == 1)
            return id_pool[$urandom_range(0, id_pool.size() - 1)];
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(MAX_ITEMS + 1, ID_SPAN - 1);
    endfunction

    function automatic int unsigned pick_member();
        if (gen_members.size() == 0)
            return pick_unknown();
        return gen_members[$urandom_range(0, gen_members.size() - 1)];
    endfunction

    // Queues a transaction and keeps a rough view of membership and both ends.
    function automatic void push_op(logic [ACT_W-1:0] act, int unsigned id,
                                    logic [OFF_W-1:0] off, int unsigned pos);
        shelf_op_t op;
        op.act = act;
        op.id  = ID_W'(id);
        op.off = off;
        op.pos = ID_W'(pos);
        pending.push_back(op);
        if (act == ACT_LOAD && id >= 1 && id <= MAX_ITEMS && !gen_member[id]
            && gen_members.size() < MAX_ITEMS)
        begin
            gen_member[id] = 1'b1;
            gen_members.push_back(id);
            if (gen_members.size() == 1)
                front_guess = id;
            back_guess = id;
            for (int k = 0; k < id_pool.size(); k++)
            begin
                if (id_pool[k] == id)
                begin
                    id_pool.delete(k);
                    break;
                end
            end
        end
        else if (act == ACT_TOP && id < ID_SPAN && gen_member[id])
            front_guess = id;
        else if (act == ACT_BOTTOM && id < ID_SPAN && gen_member[id])
            back_guess = id;
    endfunction

    function automatic void move_entry(int src, int dst);
        int unsigned moved;
        moved = shelf[src];
        shelf.delete(src);
        shelf.insert(dst, moved);
    endfunction

    // Expected outcome of one accepted transaction; updates the shadow shelf.
    function automatic void predict_shelf(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                          logic signed [OFF_W-1:0] off,
                                          logic [ID_W-1:0] pos);
        int       slot;
        int       tgt;
        bit       give;
        verdict_t v;
        slot     = -1;
        give     = 1'b1;
        v.answer = '0;
        v.err    = 1'b1;
        if (id != 0 && id <= MAX_ITEMS)
        begin
            for (int k = 0; k < shelf.size(); k++)
                if (shelf[k] == id)
                    slot = k;
        end
        case (act)
            ACT_LOAD:
                if (id != 0 && id <= MAX_ITEMS && slot < 0 && shelf.size() < MAX_ITEMS)
                begin
                    shelf.push_back(id);
                    give = 1'b0;
                end
            ACT_TOP:
                if (slot >= 0)
                begin
                    move_entry(slot, 0);
                    give = 1'b0;
                end
            ACT_BOTTOM:
                if (slot >= 0)
                begin
                    move_entry(slot, shelf.size() - 1);
                    give = 1'b0;
                end
            ACT_SHIFT:
            begin
                tgt = slot + int'(off);
                if (slot >= 0 && tgt >= 0 && tgt < shelf.size())
                begin
                    move_entry(slot, tgt);
                    give = 1'b0;
                end
            end
            ACT_ASK:
                if (slot >= 0)
                begin
                    v.answer = ID_W'(slot);
                    v.err    = 1'b0;
                end
            ACT_QUERY:
                if (pos != 0 && pos <= shelf.size())
                begin
                    v.answer = ID_W'(shelf[pos - 1]);
                    v.err    = 1'b0;
                end
            default: ;
        endcase
        if (give)
            verdicts.push_back(v);
    endfunction

    // Driver: one transaction at a time from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            action      <= '0;
            item_id     <= '0;
            offset      <= '0;
            position    <= '0;
            gap_left    = 0;
            n_sent      = 0;
            pause_state = PAUSE_OFF;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                n_sent++;
                if (n_sent == pause_first || n_sent == PAUSE_MID)
                    pause_state = PAUSE_ENTER;
            end
            if (!in_valid || in_ready)
            begin
                if (pause_state == PAUSE_ENTER)
                begin
                    // drained is registered, so wait in a further state before trusting it
                    pause_state = PAUSE_WAIT;
                    in_valid <= 1'b0;
                end
                else if (pause_state == PAUSE_WAIT)
                begin
                    if (drained)
                        pause_state = PAUSE_OFF;
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    cur = pending.pop_front();
                    action   <= cur.act;
                    item_id  <= cur.id;
                    offset   <= cur.off;
                    position <= cur.pos;
                    in_valid <= 1'b1;
                    gap_left = pick_gap(drv_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts accepted transactions, checks results, drives out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            drained    <= 1'b1;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result, answer %0d, error_flag %0b",
                             $time, answer, error_flag);
                    n_fail++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (answer !== want.answer)
                    begin
                        $display("%0t: answer mismatch, expected %0d, got %0d",
                                 $time, want.answer, answer);
                        n_fail++;
                    end
                    if (error_flag !== want.err)
                    begin
                        $display("%0t: error_flag mismatch, expected %0b, got %0b",
                                 $time, want.err, error_flag);
                        n_fail++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_shelf(action, item_id, offset, position);
            drained <= (verdicts.size() == 0);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(mon_calm);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet);
                $display("FAIL ordered_list_move_and_rank");
                $finish;
            end
        end
    end

    initial
    begin
        int          r;
        int          sel;
        int          tail;
        int unsigned id;
        int unsigned n;
        logic [OFF_W-1:0] off;
        int unsigned pos;

        for (int k = 1; k <= MAX_ITEMS; k++)
            id_pool.push_back(k);

        // directed: empty list, bad ids, duplicates, moves past both ends
        push_op(ACT_ASK,     5,    OFF_STAY, 0);
        push_op(ACT_QUERY,   0,    OFF_STAY, 1);
        push_op(ACT_QUERY,   0,    OFF_STAY, 0);
        push_op(ACT_TOP,     3,    OFF_STAY, 0);
        push_op(ACT_LOAD,    0,    OFF_STAY, 0);
        push_op(ACT_LOAD,    MAX_ITEMS + 1, OFF_STAY, 0);
        push_op(ACT_LOAD,    ID_SPAN - 1,   OFF_WRAP, ID_SPAN - 1);
        push_op(ACT_LOAD,    MAX_ITEMS,     OFF_STAY, 0);
        push_op(ACT_LOAD,    1,    OFF_STAY, 0);
        push_op(ACT_LOAD,    7,    OFF_STAY, 0);
        push_op(ACT_LOAD,    1,    OFF_STAY, 0);
        push_op(ACT_SHIFT,   MAX_ITEMS, OFF_UP, 0);
        push_op(ACT_SHIFT,   7,    OFF_DOWN, 0);
        push_op(ACT_SHIFT,   1,    OFF_WRAP, 0);
        push_op(ACT_SHIFT,   1,    OFF_STAY, 0);
        push_op(ACT_SHIFT,   1,    OFF_UP,   0);
        push_op(ACT_TOP,     7,    OFF_STAY, 0);
        push_op(ACT_BOTTOM,  1,    OFF_STAY, 0);
        push_op(ACT_ASK,     1,    OFF_STAY, 0);
        push_op(ACT_QUERY,   0,    OFF_STAY, 3);
        push_op(ACT_QUERY,   0,    OFF_STAY, 4);
        push_op(ACT_QUERY,   ID_SPAN - 1, OFF_UP, ID_SPAN - 1);
        push_op(ACT_RSVD_LO, 1,    OFF_STAY, 1);
        push_op(ACT_RSVD_HI, ID_SPAN - 1, OFF_UP, ID_SPAN - 1);
        push_op(ACT_ASK,     MAX_ITEMS + 1, OFF_STAY, 0);
        push_op(ACT_BOTTOM,  0,    OFF_STAY, 0);
        pause_first = pending.size();

        // random: grow the list to full with moves mixed in, then run a tail at full
        tail = 0;
        while (gen_members.size() < MAX_ITEMS || tail < TAIL_ITEMS)
        begin
            if (gen_members.size() >= MAX_ITEMS)
                tail++;
            r   = $urandom_range(0, 99);
            off = OFF_W'($urandom_range(0, 3));
            pos = $urandom_range(0, ID_SPAN - 1);
            n   = gen_members.size();
            if (r < 68)
            begin
                if (id_pool.size() > 0)
                    id = id_pool[$urandom_range(0, id_pool.size() - 1)];
                else
                    id = pick_member();
                push_op(ACT_LOAD, id, off, pos);
            end
            else if (r < 70)
                push_op(ACT_LOAD, pick_member(), off, pos);
            else if (r < 72)
                push_op(ACT_LOAD, pick_unknown(), off, pos);
            else if (r < 77)
                push_op(ACT_TOP, ($urandom_range(0, 9) == 0) ? pick_unknown() : pick_member(),
                        off, pos);
            else if (r < 82)
                push_op(ACT_BOTTOM,
                        ($urandom_range(0, 9) == 0) ? pick_unknown() : pick_member(), off, pos);
            else if (r < 89)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    push_op(ACT_SHIFT, front_guess,
                            ($urandom_range(0, 1) == 1) ? OFF_UP : OFF_WRAP, pos);
                else if (sel < 6)
                    push_op(ACT_SHIFT, back_guess, OFF_DOWN, pos);
                else if (sel < 9)
                    push_op(ACT_SHIFT, pick_member(), off, pos);
                else
                    push_op(ACT_SHIFT, pick_unknown(), off, pos);
            end
            else if (r < 94)
                push_op(ACT_ASK, ($urandom_range(0, 7) == 0) ? pick_unknown() : pick_member(),
                        off, pos);
            else if (r < 98)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6 && n > 0)
                    pos = $urandom_range(1, n);
                else if (sel == 6)
                    pos = 0;
                else if (sel == 7)
                    pos = n + 1;
                push_op(ACT_QUERY, $urandom_range(0, ID_SPAN - 1), off, pos);
            end
            else
                push_op((r == 98) ? ACT_RSVD_LO : ACT_RSVD_HI,
                        $urandom_range(0, ID_SPAN - 1), off, pos);
        end
        n_total = pending.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge clk);
        // the last accepted transaction is predicted by now
        @(posedge clk);
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (n_fail == 0)
            $display("PASS ordered_list_move_and_rank");
        else
            $display("FAIL ordered_list_move_and_rank");
        $finish;
    end

endmodule
